@@ rtl/vrdr_pkg.sv @@
`timescale 1ns / 1ps

package vrdr_pkg;

   // field widths
   localparam int SPEED_W     = 16;
   localparam int VMAX_W      = 15;
   localparam int ACCEL_W     = 18;
   localparam int DT_W        = 16;
   localparam int STEP_W      = 20;
   localparam int HEAD_W      = 16;
   localparam int POS_OUT_W   = 32;

   // sine table entries, q1.16 with sign
   localparam int TRIG_W      = 18;

   // shared multiplier
   localparam int MUL_A_W     = 21;
   localparam int MUL_B_W     = 31;
   localparam int PROD_W      = 52;

   // ramp step is accel * dt >> 12
   localparam int RAMP_STEP_W = 22;
   // position increment is step_distance * trig >> 16
   localparam int DELTA_W     = 22;

   // 2^32 / (2 pi), turns radians q4.16 into binary-angle units
   localparam logic [MUL_B_W-1:0] INV_TWO_PI_Q32 = 31'd683565276;

   // csr port
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 18;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MAX_SPEED_LINEAR  = 2'd0,
      CSR_MAX_SPEED_ANGULAR = 2'd1,
      CSR_MAX_ACCEL_LINEAR  = 2'd2,
      CSR_MAX_ACCEL_ANGULAR = 2'd3
   } csr_index_type;

   localparam logic [VMAX_W-1:0]  MAX_SPEED_LINEAR_RST  = 15'd4096;
   localparam logic [VMAX_W-1:0]  MAX_SPEED_ANGULAR_RST = 15'd6431;
   localparam logic [ACCEL_W-1:0] MAX_ACCEL_LINEAR_RST  = 18'd255744;
   localparam logic [ACCEL_W-1:0] MAX_ACCEL_ANGULAR_RST = 18'd255744;

endpackage

@@ rtl/vrdr_ramp.sv @@
`timescale 1ns / 1ps

module vrdr_ramp
   import vrdr_pkg::*;
(
   input  logic signed [SPEED_W-1:0]     cur,
   input  logic signed [SPEED_W-1:0]     tgt,
   input  logic        [VMAX_W-1:0]      vmax,
   input  logic        [RAMP_STEP_W-1:0] step,
   output logic signed [SPEED_W-1:0]     result
);

   localparam int RW = RAMP_STEP_W + 2;

   logic signed [RW-1:0] cur_x;
   logic signed [RW-1:0] tgt_x;
   logic signed [RW-1:0] vmax_x;
   logic signed [RW-1:0] step_x;
   logic signed [RW-1:0] up_x;
   logic signed [RW-1:0] dn_x;
   logic signed [RW-1:0] v;

   always_comb begin
      cur_x  = RW'(cur);
      tgt_x  = RW'(tgt);
      vmax_x = $signed(RW'(vmax));
      step_x = $signed(RW'(step));
      up_x   = cur_x + step_x;
      dn_x   = cur_x - step_x;
      v      = tgt_x;
      if (tgt_x > cur_x) begin
         if (vmax_x < v) begin
            v = vmax_x;
         end
         if (up_x < v) begin
            v = up_x;
         end
      end else if (tgt_x < cur_x) begin
         if (-vmax_x > v) begin
            v = -vmax_x;
         end
         if (dn_x > v) begin
            v = dn_x;
         end
      end
      result = v[SPEED_W-1:0];
   end

endmodule

@@ rtl/vrdr_mul.sv @@
`timescale 1ns / 1ps

module vrdr_mul
   import vrdr_pkg::*;
(
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [MUL_A_W-1:0] a,
   input  logic signed [MUL_B_W-1:0] b,
   output logic signed [PROD_W-1:0]  prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(a) * PROD_W'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

@@ rtl/velocity_ramp_dead_reckoning.sv @@
// velocity ramp and unicycle dead reckoning, one tick per request
// an accepted request steps through ST_ACC_L to ST_DONE, then rsp_valid is raised
// one request at a time, taken only in ST_IDLE; set by the single shared multiplier
//   (seven products per tick) and the registered sine table read
// reset: synchronous, active high; clears speeds, pose and handshakes, loads default limits
`timescale 1ns / 1ps

module velocity_ramp_dead_reckoning
   import vrdr_pkg::*;
#(
   parameter int SINE_TABLE_ENTRIES = 1024,
   parameter int POSITION_WIDTH     = 32
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [SPEED_W-1:0]    req_target_speed_linear,
   input  logic signed [SPEED_W-1:0]    req_target_speed_angular,
   input  logic        [DT_W-1:0]       req_elapsed_time,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [POS_OUT_W-1:0]  rsp_pos_x,
   output logic signed [POS_OUT_W-1:0]  rsp_pos_y,
   output logic        [HEAD_W-1:0]     rsp_heading,
   output logic signed [SPEED_W-1:0]    rsp_speed_linear,
   output logic signed [SPEED_W-1:0]    rsp_speed_angular,
   output logic signed [STEP_W-1:0]     rsp_step_distance,
   output logic signed [STEP_W-1:0]     rsp_step_angle,

   input  logic                         csr_wr_en,
   input  logic        [CSR_ADDR_W-1:0] csr_index,
   input  logic        [CSR_DATA_W-1:0] csr_wdata
);

   // ------------------------------------------------------------------
   // sine table, built at elaboration from an integer taylor series
   // ------------------------------------------------------------------
   localparam int IDX_W  = $clog2(SINE_TABLE_ENTRIES);
   localparam int IP_W   = IDX_W + 17;
   localparam int PSUM_W = POSITION_WIDTH + 1;
   localparam int CL_W   = (POSITION_WIDTH > POS_OUT_W) ? POSITION_WIDTH : POS_OUT_W;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   localparam logic signed [CL_W-1:0] CL_MAX = CL_W'($signed(32'h7fff_ffff));
   localparam logic signed [CL_W-1:0] CL_MIN = CL_W'($signed(32'h8000_0000));

   localparam logic [HEAD_W-1:0] QUARTER_TURN = 16'h4000;

   typedef logic signed [TRIG_W-1:0] sine_rom_type [SINE_TABLE_ENTRIES];

   // sine of a binary angle, q1.16
   function automatic logic signed [TRIG_W-1:0] bin_sine(input logic [HEAD_W-1:0] ang);
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] mag;
      r = {50'd0, ang[13:0]};
      if (ang[14]) begin
         r = 64'd16384 - r;
      end
      x    = (r * PI_Q30) >> 15;
      term = x;
      pos  = x;
      neg  = 64'd0;
      for (int n = 1; n <= 7; n++) begin
         term = (((term * x) >> 30) * x) >> 30;
         case (n)
            1:       term = term / 64'd6;
            2:       term = term / 64'd20;
            3:       term = term / 64'd42;
            4:       term = term / 64'd72;
            5:       term = term / 64'd110;
            6:       term = term / 64'd156;
            default: term = term / 64'd210;
         endcase
         if (n % 2 == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      mag = (pos - neg + 64'd8192) >> 14;
      if (ang[15]) begin
         mag = -mag;
      end
      return mag[TRIG_W-1:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  ang;
      for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
         ang    = (64'(k) * 64'd65536) / SINE_TABLE_ENTRIES;
         rom[k] = bin_sine(ang[HEAD_W-1:0]);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // ------------------------------------------------------------------
   // sequencer states
   // ------------------------------------------------------------------
   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,  // wait for a request
      ST_ACC_L  = 11'b000_0000_0010,  // linear ramp step product
      ST_ACC_A  = 11'b000_0000_0100,  // angular ramp step product, ramp linear
      ST_RAMP_A = 11'b000_0000_1000,  // ramp angular, linear speed * dt
      ST_DS     = 11'b000_0001_0000,  // latch step distance, angular speed * dt
      ST_DTH    = 11'b000_0010_0000,  // latch step angle, angle to binary units
      ST_HEAD   = 11'b000_0100_0000,  // heading update, cosine read
      ST_MUL_X  = 11'b000_1000_0000,  // distance * cos, sine read
      ST_MUL_Y  = 11'b001_0000_0000,  // x update, distance * sin
      ST_POS_Y  = 11'b010_0000_0000,  // y update
      ST_DONE   = 11'b100_0000_0000   // hand over to the output register
   } state_type;

   state_type state_ff;
   state_type state_in;

   // limits
   logic [VMAX_W-1:0]  max_speed_linear_ff;
   logic [VMAX_W-1:0]  max_speed_angular_ff;
   logic [ACCEL_W-1:0] max_accel_linear_ff;
   logic [ACCEL_W-1:0] max_accel_angular_ff;

   // latched request
   logic signed [SPEED_W-1:0] tgt_l_ff;
   logic signed [SPEED_W-1:0] tgt_a_ff;
   logic        [DT_W-1:0]    dt_ff;

   // persistent state
   logic signed [SPEED_W-1:0]        cur_l_ff;
   logic signed [SPEED_W-1:0]        cur_a_ff;
   logic signed [POSITION_WIDTH-1:0] pos_x_ff;
   logic signed [POSITION_WIDTH-1:0] pos_y_ff;
   logic        [HEAD_W-1:0]         heading_ff;
   logic        [HEAD_W-1:0]         heading_in;

   // per-tick results
   logic signed [STEP_W-1:0] ds_ff;
   logic signed [STEP_W-1:0] dth_ff;

   // table read
   logic        [HEAD_W-1:0] rom_ang;
   logic        [IP_W-1:0]   rom_ip;
   logic        [IDX_W-1:0]  rom_idx;
   logic signed [TRIG_W-1:0] rom_q_ff;

   // shared multiplier
   logic                      mul_en;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;

   // ramp unit, shared between the two speeds
   logic signed [SPEED_W-1:0]     ramp_cur;
   logic signed [SPEED_W-1:0]     ramp_tgt;
   logic        [VMAX_W-1:0]      ramp_vmax;
   logic        [RAMP_STEP_W-1:0] ramp_step;
   logic signed [SPEED_W-1:0]     ramp_result;

   // position adder, shared between x and y
   logic signed [POSITION_WIDTH-1:0] pos_sel;
   logic signed [DELTA_W-1:0]        pos_delta;
   logic signed [PSUM_W-1:0]         pos_sum;
   logic signed [POSITION_WIDTH-1:0] pos_sat;

   logic [47:0] head_sum;

   // output register
   logic                        rsp_valid_ff;
   logic signed [POS_OUT_W-1:0] rsp_pos_x_ff;
   logic signed [POS_OUT_W-1:0] rsp_pos_y_ff;
   logic        [HEAD_W-1:0]    rsp_heading_ff;
   logic signed [SPEED_W-1:0]   rsp_speed_linear_ff;
   logic signed [SPEED_W-1:0]   rsp_speed_angular_ff;
   logic signed [STEP_W-1:0]    rsp_step_distance_ff;
   logic signed [STEP_W-1:0]    rsp_step_angle_ff;

   logic req_fire;
   logic out_load;

   // clamp a wide position to the 32-bit output range
   function automatic logic signed [POS_OUT_W-1:0] clamp_out(
      input logic signed [POSITION_WIDTH-1:0] v
   );
      logic signed [CL_W-1:0] ext;
      ext = CL_W'(v);
      if (ext > CL_MAX) begin
         return CL_MAX[POS_OUT_W-1:0];
      end else if (ext < CL_MIN) begin
         return CL_MIN[POS_OUT_W-1:0];
      end
      return ext[POS_OUT_W-1:0];
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   // the output register takes a new tick once the last one is gone or leaving
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) begin
                       state_in = ST_ACC_L;
                    end
         ST_ACC_L:  state_in = ST_ACC_A;
         ST_ACC_A:  state_in = ST_RAMP_A;
         ST_RAMP_A: state_in = ST_DS;
         ST_DS:     state_in = ST_DTH;
         ST_DTH:    state_in = ST_HEAD;
         ST_HEAD:   state_in = ST_MUL_X;
         ST_MUL_X:  state_in = ST_MUL_Y;
         ST_MUL_Y:  state_in = ST_POS_Y;
         ST_POS_Y:  state_in = ST_DONE;
         ST_DONE:   if (out_load) begin
                       state_in = ST_IDLE;
                    end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // multiplier operand selection
   // ------------------------------------------------------------------
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         ST_ACC_L: begin
            // accel q10.8 * dt q0.16
            mul_a = $signed(MUL_A_W'(max_accel_linear_ff));
            mul_b = $signed(MUL_B_W'(dt_ff));
         end
         ST_ACC_A: begin
            mul_a = $signed(MUL_A_W'(max_accel_angular_ff));
            mul_b = $signed(MUL_B_W'(dt_ff));
         end
         ST_RAMP_A: begin
            // new linear speed times dt
            mul_a = MUL_A_W'(cur_l_ff);
            mul_b = $signed(MUL_B_W'(dt_ff));
         end
         ST_DS: begin
            mul_a = MUL_A_W'(cur_a_ff);
            mul_b = $signed(MUL_B_W'(dt_ff));
         end
         ST_DTH: begin
            // step angle straight off the product register
            mul_a = MUL_A_W'($signed(prod[31:12]));
            mul_b = $signed(INV_TWO_PI_Q32);
         end
         ST_MUL_X, ST_MUL_Y: begin
            mul_a = MUL_A_W'(ds_ff);
            mul_b = MUL_B_W'(rom_q_ff);
         end
         default: mul_en = 1'b0;
      endcase
   end

   vrdr_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // ------------------------------------------------------------------
   // speed ramp
   // ------------------------------------------------------------------
   always_comb begin
      ramp_step = prod[33:12];
      if (state_ff == ST_ACC_A) begin
         ramp_cur  = cur_l_ff;
         ramp_tgt  = tgt_l_ff;
         ramp_vmax = max_speed_linear_ff;
      end else begin
         ramp_cur  = cur_a_ff;
         ramp_tgt  = tgt_a_ff;
         ramp_vmax = max_speed_angular_ff;
      end
   end

   vrdr_ramp u_ramp (
      .cur    (ramp_cur),
      .tgt    (ramp_tgt),
      .vmax   (ramp_vmax),
      .step   (ramp_step),
      .result (ramp_result)
   );

   // ------------------------------------------------------------------
   // heading: round the binary-angle increment to nearest, wrap mod a turn
   // ------------------------------------------------------------------
   assign head_sum   = prod[47:0] + 48'h0000_8000_0000;
   assign heading_in = heading_ff + head_sum[47:32];

   // cosine read while the heading is updated, sine read in the next state
   always_comb begin
      if (state_ff == ST_HEAD) begin
         rom_ang = heading_in + QUARTER_TURN;
      end else begin
         rom_ang = heading_ff;
      end
      rom_ip  = IP_W'(rom_ang) * IP_W'(SINE_TABLE_ENTRIES);
      rom_idx = rom_ip[IDX_W+15:16];
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= SINE_ROM[rom_idx];
   end

   // ------------------------------------------------------------------
   // position update with saturation
   // ------------------------------------------------------------------
   always_comb begin
      pos_sel   = (state_ff == ST_MUL_Y) ? pos_x_ff : pos_y_ff;
      pos_delta = prod[37:16];
      pos_sum   = PSUM_W'(pos_sel) + PSUM_W'(pos_delta);
      if (pos_sum[POSITION_WIDTH] != pos_sum[POSITION_WIDTH-1]) begin
         pos_sat = pos_sum[POSITION_WIDTH] ? {1'b1, {(POSITION_WIDTH-1){1'b0}}}
                                           : {1'b0, {(POSITION_WIDTH-1){1'b1}}};
      end else begin
         pos_sat = pos_sum[POSITION_WIDTH-1:0];
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_IDLE;
         max_speed_linear_ff  <= MAX_SPEED_LINEAR_RST;
         max_speed_angular_ff <= MAX_SPEED_ANGULAR_RST;
         max_accel_linear_ff  <= MAX_ACCEL_LINEAR_RST;
         max_accel_angular_ff <= MAX_ACCEL_ANGULAR_RST;
         cur_l_ff             <= '0;
         cur_a_ff             <= '0;
         pos_x_ff             <= '0;
         pos_y_ff             <= '0;
         heading_ff           <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_MAX_SPEED_LINEAR:  max_speed_linear_ff  <= csr_wdata[VMAX_W-1:0];
               CSR_MAX_SPEED_ANGULAR: max_speed_angular_ff <= csr_wdata[VMAX_W-1:0];
               CSR_MAX_ACCEL_LINEAR:  max_accel_linear_ff  <= csr_wdata[ACCEL_W-1:0];
               CSR_MAX_ACCEL_ANGULAR: max_accel_angular_ff <= csr_wdata[ACCEL_W-1:0];
               default: ;
            endcase
         end

         if (state_ff == ST_ACC_A) begin
            cur_l_ff <= ramp_result;
         end
         if (state_ff == ST_RAMP_A) begin
            cur_a_ff <= ramp_result;
         end
         if (state_ff == ST_HEAD) begin
            heading_ff <= heading_in;
         end
         if (state_ff == ST_MUL_Y) begin
            pos_x_ff <= pos_sat;
         end
         if (state_ff == ST_POS_Y) begin
            pos_y_ff <= pos_sat;
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         tgt_l_ff <= req_target_speed_linear;
         tgt_a_ff <= req_target_speed_angular;
         dt_ff    <= req_elapsed_time;
      end
      if (state_ff == ST_DS) begin
         ds_ff <= prod[31:12];
      end
      if (state_ff == ST_DTH) begin
         dth_ff <= prod[31:12];
      end
      if (out_load) begin
         rsp_pos_x_ff         <= clamp_out(pos_x_ff);
         rsp_pos_y_ff         <= clamp_out(pos_y_ff);
         rsp_heading_ff       <= heading_ff;
         rsp_speed_linear_ff  <= cur_l_ff;
         rsp_speed_angular_ff <= cur_a_ff;
         rsp_step_distance_ff <= ds_ff;
         rsp_step_angle_ff    <= dth_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pos_x         = rsp_pos_x_ff;
   assign rsp_pos_y         = rsp_pos_y_ff;
   assign rsp_heading       = rsp_heading_ff;
   assign rsp_speed_linear  = rsp_speed_linear_ff;
   assign rsp_speed_angular = rsp_speed_angular_ff;
   assign rsp_step_distance = rsp_step_distance_ff;
   assign rsp_step_angle    = rsp_step_angle_ff;

endmodule

@@ rtl/vrdr_checker.sv @@
`timescale 1ns / 1ps

module vrdr_checker
   import vrdr_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [POS_OUT_W-1:0]  rsp_pos_x,
   input logic signed [POS_OUT_W-1:0]  rsp_pos_y,
   input logic        [HEAD_W-1:0]     rsp_heading,
   input logic signed [SPEED_W-1:0]    rsp_speed_linear,
   input logic signed [SPEED_W-1:0]    rsp_speed_angular,
   input logic signed [STEP_W-1:0]     rsp_step_distance,
   input logic signed [STEP_W-1:0]     rsp_step_angle
);

   // no response pending after reset
   a_reset_idle : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // a stalled response holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y)
         && $stable(rsp_heading) && $stable(rsp_step_distance))
      else $error("stalled response changed");

   // one tick at a time: busy right after a request
   a_busy : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a tick runs through the sequencer states, so no new response straight after a request
   a_no_early_rsp : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response too early");

   // standing still moves nothing
   a_zero_speed : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_speed_linear != 0 || rsp_step_distance == 0)
         && (rsp_speed_angular != 0 || rsp_step_angle == 0))
      else $error("step without speed");

endmodule

bind velocity_ramp_dead_reckoning vrdr_checker u_vrdr_checker (.*);
